// ===== src/cce_pkg.sv =====
// cce_pkg: shared types and constants for the configurable crc engine
// no dependencies
`default_nettype none
package cce_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned REG_W   = 32;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned WCODE_W = 2;

  localparam logic [IDX_W-1:0] REG_POLYNOMIAL = 2'd0;
  localparam logic [IDX_W-1:0] REG_WIDTH_CODE = 2'd1;
  localparam logic [IDX_W-1:0] REG_INIT_VALUE = 2'd2;
  localparam logic [IDX_W-1:0] REG_XOR_OUT    = 2'd3;

  localparam logic [REG_W-1:0]   POLY_RST  = 32'h0000_1021;
  localparam logic [WCODE_W-1:0] WCODE_RST = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic din;
  } crc_ctrl_t;

endpackage
`default_nettype wire

// ===== src/cce_crc_unit.sv =====
// cce_crc_unit: one-bit-per-cycle crc shift register with width masking
// depends on cce_pkg
`default_nettype none
module cce_crc_unit #(
  parameter int unsigned CRC_W = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cce_pkg::crc_ctrl_t                ctrl,
  input  wire logic [cce_pkg::REG_W-1:0]         polynomial,
  input  wire logic [cce_pkg::WCODE_W-1:0]       width_code,
  input  wire logic [cce_pkg::REG_W-1:0]         init_value,
  input  wire logic [cce_pkg::REG_W-1:0]         xor_out,
  output logic      [cce_pkg::REG_W-1:0]         crc_result
);

  localparam int unsigned IDX_W = (CRC_W > 1) ? $clog2(CRC_W) : 1;

  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic [CRC_W-1:0] mask;
  logic [CRC_W-1:0] cur;
  logic [CRC_W-1:0] shifted;
  logic [6:0]       wid_full;
  logic [6:0]       wid;
  logic [IDX_W-1:0] top_idx;
  logic             fb;

  // active width, limited to the register width
  always_comb begin
    wid_full = 7'({5'd0, width_code} + 7'd1) << 3;
    wid      = (wid_full > 7'(CRC_W)) ? 7'(CRC_W) : wid_full;
    top_idx  = IDX_W'(wid - 7'd1);
    for (int i = 0; i < CRC_W; i++) begin
      mask[i] = (7'(i) < wid);
    end
  end

  always_comb begin
    cur     = crc_r & mask;
    fb      = cur[top_idx] ^ ctrl.din;
    shifted = (cur << 1) & mask;
    crc_nxt = crc_r;
    if (ctrl.load) begin
      crc_nxt = init_value[CRC_W-1:0] & mask;
    end else if (ctrl.step) begin
      crc_nxt = fb ? (shifted ^ (polynomial[CRC_W-1:0] & mask)) : shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc_result = cce_pkg::REG_W'((crc_r ^ xor_out[CRC_W-1:0]) & mask);

endmodule
`default_nettype wire

// ===== src/configurable_crc_engine_core.sv =====
// configurable_crc_engine_core: msb-first crc over bytes with partial last byte
// depends on cce_pkg and cce_crc_unit
// one bit per cycle: a byte with n valid bits shifts once per valid bit, the next byte of the message
// is taken on its last shift; a last or zero-bit byte adds an emit state, where a last byte's result
// is registered; the next byte is then taken back in idle, and that emit waits while an older result waits
// synchronous active-low reset restores register defaults and arms a new message
`default_nettype none
module configurable_crc_engine_core #(
  parameter int unsigned MAX_CRC_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [cce_pkg::IDX_W-1:0]         cfg_index,
  input  wire logic [cce_pkg::REG_W-1:0]         cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [7:0]                        in_data_byte,
  input  wire logic [3:0]                        in_valid_bits,
  input  wire logic                              in_last_byte,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [31:0]                            out_crc_value
);

  localparam int unsigned CRC_W = (MAX_CRC_WIDTH < cce_pkg::REG_W) ?
                                  MAX_CRC_WIDTH : cce_pkg::REG_W;

  logic [cce_pkg::REG_W-1:0]   polynomial_r;
  logic [cce_pkg::WCODE_W-1:0] width_code_r;
  logic [cce_pkg::REG_W-1:0]   init_value_r;
  logic [cce_pkg::REG_W-1:0]   xor_out_r;

  cce_pkg::state_t             state_r, state_nxt;
  logic [cce_pkg::BYTE_W-1:0]  data_r, data_nxt;
  logic [cce_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        last_r, last_nxt;
  logic                        start_r, start_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [31:0]                 out_crc_r, out_crc_nxt;

  logic                        accept;
  logic [cce_pkg::CNT_W-1:0]   nbits;
  logic                        emit;
  logic [cce_pkg::REG_W-1:0]   crc_result;
  cce_pkg::crc_ctrl_t          ctrl;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polynomial_r <= cce_pkg::POLY_RST;
      width_code_r <= cce_pkg::WCODE_RST;
      init_value_r <= '0;
      xor_out_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cce_pkg::REG_POLYNOMIAL: polynomial_r <= cfg_wdata;
        cce_pkg::REG_WIDTH_CODE: width_code_r <= cfg_wdata[cce_pkg::WCODE_W-1:0];
        cce_pkg::REG_INIT_VALUE: init_value_r <= cfg_wdata;
        cce_pkg::REG_XOR_OUT:    xor_out_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nbits    = (in_valid_bits > 4'd8) ? 4'd8 : in_valid_bits;
  assign in_ready = (state_r == cce_pkg::ST_IDLE) ||
                    ((state_r == cce_pkg::ST_SHIFT) && (cnt_r == 4'd1) && !last_r);
  assign accept   = in_valid && in_ready;
  assign emit     = (state_r == cce_pkg::ST_EMIT) && last_r && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    data_nxt      = data_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    start_nxt     = start_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_crc_nxt   = out_crc_r;
    ctrl.load     = accept && start_r;
    ctrl.step     = (state_r == cce_pkg::ST_SHIFT);
    ctrl.din      = data_r[cce_pkg::BYTE_W-1];

    unique case (state_r)
      cce_pkg::ST_IDLE: ;
      cce_pkg::ST_SHIFT: begin
        data_nxt = data_r << 1;
        cnt_nxt  = cnt_r - 4'd1;
        if (cnt_r == 4'd1) begin
          state_nxt = last_r ? cce_pkg::ST_EMIT : cce_pkg::ST_IDLE;
        end
      end
      cce_pkg::ST_EMIT: begin
        if (!last_r) begin
          state_nxt = cce_pkg::ST_IDLE;
        end else if (emit) begin
          out_valid_nxt = 1'b1;
          out_crc_nxt   = crc_result;
          start_nxt     = 1'b1;
          state_nxt     = cce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cce_pkg::ST_IDLE;
    endcase

    // new transaction overrides the idle or final-bit transition
    if (accept) begin
      data_nxt  = in_data_byte;
      cnt_nxt   = nbits;
      last_nxt  = in_last_byte;
      start_nxt = 1'b0;
      state_nxt = (nbits == 4'd0) ? cce_pkg::ST_EMIT : cce_pkg::ST_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cce_pkg::ST_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r    <= data_nxt;
    out_crc_r <= out_crc_nxt;
  end

  cce_crc_unit #(
    .CRC_W (CRC_W)
  ) u_crc (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .polynomial (polynomial_r),
    .width_code (width_code_r),
    .init_value (init_value_r),
    .xor_out    (xor_out_r),
    .crc_result (crc_result)
  );

  assign out_valid     = out_valid_r;
  assign out_crc_value = out_crc_r;

  a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cce_pkg::ST_SHIFT) |-> ((cnt_r != 4'd0) && (cnt_r <= 4'd8)))
    else $error("shift state with bad bit count");

  a_load_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.load && ctrl.step))
    else $error("crc load and step together");

  a_emit_arms: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (out_valid_r && start_r && (state_r == cce_pkg::ST_IDLE)))
    else $error("result not registered or message not rearmed");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> (state_r == cce_pkg::ST_IDLE))
    else $error("message start armed while busy");

endmodule
`default_nettype wire

// ===== test/crc_result_checker.sv =====
// crc_result_checker: watches the config port and both channels of the crc engine,
// predicts each finished crc and compares it with the result transactions
// depends on cce_pkg
module crc_result_checker (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [cce_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [cce_pkg::REG_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic [7:0]                in_data_byte,
  input  wire logic [3:0]                in_valid_bits,
  input  wire logic                      in_last_byte,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic [31:0]               out_crc_value,
  output int                             fail_count,
  output int                             pending_count
);

  logic [31:0] poly_r, init_r, xor_r, run_crc, crc, mask, want;
  logic [cce_pkg::WCODE_W-1:0] wcode_r;
  logic msg_start, top;
  int width, nbits, errs, i;
  logic [31:0] expected_crc_q[$];

  initial begin
    errs = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      poly_r = cce_pkg::POLY_RST;
      wcode_r = cce_pkg::WCODE_RST;
      init_r = '0;
      xor_r = '0;
      run_crc = '0;
      msg_start = 1'b1;
      expected_crc_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cce_pkg::REG_POLYNOMIAL: poly_r = cfg_wdata;
          cce_pkg::REG_WIDTH_CODE: wcode_r = cfg_wdata[cce_pkg::WCODE_W-1:0];
          cce_pkg::REG_INIT_VALUE: init_r = cfg_wdata;
          cce_pkg::REG_XOR_OUT:    xor_r = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        width = 8 * (int'(wcode_r) + 1);
        mask = 32'hFFFF_FFFF >> (32 - width);
        nbits = (in_valid_bits > 4'd8) ? 8 : int'(in_valid_bits);
        if (msg_start) begin
          run_crc = init_r & mask;
          msg_start = 1'b0;
        end
        crc = run_crc & mask;
        for (i = 0; i < nbits; i++) begin
          top = crc[width-1];
          crc = (crc << 1) & mask;
          if (top ^ in_data_byte[7-i]) crc = crc ^ (poly_r & mask);
        end
        run_crc = crc;
        if (in_last_byte) begin
          expected_crc_q.push_back((crc ^ xor_r) & mask);
          msg_start = 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        if (expected_crc_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected crc transaction: got %h", out_crc_value);
        end else begin
          want = expected_crc_q.pop_front();
          if (out_crc_value !== want) begin
            errs++;
            if (errs <= 10)
              $display("crc mismatch: expected %h, got %h", want, out_crc_value);
          end
        end
      end
    end
    pending_count <= expected_crc_q.size();
    fail_count <= errs;
  end

endmodule

// ===== test/tb_configurable_crc_engine_core.sv =====
// tb_configurable_crc_engine_core: drives messages and register settings into the crc engine
// with random idling on both channels; verdict from crc_result_checker
// depends on cce_pkg, configurable_crc_engine_core and crc_result_checker
module tb_configurable_crc_engine_core;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 16;

  localparam logic [31:0] POLY_SET [5] =
    '{32'h0000_0007, 32'h04C1_1DB7, 32'h0086_4CFB, 32'hFFFF_FFFF, 32'h0000_0000};
  localparam logic [1:0] WCODE_SET [5] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd3};
  localparam logic [31:0] INIT_SET [5] =
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00B7_04CE, 32'hFFFF_FFFF, 32'h0000_0000};
  localparam logic [31:0] XOR_SET [5] =
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678};

  logic clk, rst_n;
  logic cfg_we;
  logic [cce_pkg::IDX_W-1:0] cfg_index;
  logic [cce_pkg::REG_W-1:0] cfg_wdata;
  logic in_valid, in_ready, in_last_byte;
  logic [7:0] in_data_byte;
  logic [3:0] in_valid_bits;
  logic out_valid, out_ready;
  logic [31:0] out_crc_value;
  int fail_count, pending_count;
  int send_idle_pct, recv_idle_pct, stall_req, quiet_cycles;

  configurable_crc_engine_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_valid_bits(in_valid_bits), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_crc_value(out_crc_value)
  );

  crc_result_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_data_byte(in_data_byte), .in_valid_bits(in_valid_bits), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_crc_value(out_crc_value),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, or a long hold-off on request
  initial begin
    int hold;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req != 0) begin
        hold = stall_req;
        stall_req = 0;
        out_ready <= 1'b0;
        repeat (hold - 1) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic [3:0] nbits, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_valid_bits <= nbits;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait for every crc to come out and the engine to finish shifting
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cce_pkg::IDX_W-1:0] idx,
                           input logic [cce_pkg::REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [31:0] poly, input logic [1:0] wcode,
                               input logic [31:0] init, input logic [31:0] xo);
    logic [31:0] wval;
    wval = $urandom;
    wval[1:0] = wcode;
    write_reg(cce_pkg::REG_POLYNOMIAL, poly);
    write_reg(cce_pkg::REG_WIDTH_CODE, wval);
    write_reg(cce_pkg::REG_INIT_VALUE, init);
    write_reg(cce_pkg::REG_XOR_OUT, xo);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed messages, some with odd bit counts anywhere
  task automatic run_traffic(input int target);
    int sent, len, k;
    bit ragged;
    logic [3:0] vb;
    sent = 0;
    while (sent < target) begin
      len = $urandom_range(8, 1);
      if ($urandom_range(9, 0) == 0) len = $urandom_range(40, 9);
      ragged = ($urandom_range(9, 0) == 0);
      for (k = 0; k < len; k++) begin
        if (ragged) vb = 4'($urandom_range(15, 0));
        else if (k == len - 1) vb = 4'($urandom_range(8, 1));
        else vb = 4'd8;
        send_byte(8'($urandom_range(255, 0)), vb, k == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    int p;
    string check_str;
    send_idle_pct = 7;
    recv_idle_pct = 66;
    stall_req = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_valid_bits <= '0;
    in_last_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed messages on the reset settings
    send_byte(8'h00, 4'd8, 1'b1);
    send_byte(8'hFF, 4'd8, 1'b1);
    check_str = "123456789";
    for (p = 0; p < 9; p++) send_byte(check_str[p], 4'd8, p == 8);
    send_byte(8'hA5, 4'd0, 1'b1);
    send_byte(8'hA5, 4'd15, 1'b0);
    send_byte(8'h6E, 4'd3, 1'b1);
    send_byte(8'h80, 4'd1, 1'b1);
    // width change part-way through a message
    send_byte(8'h5A, 4'd8, 1'b0);
    settle();
    write_reg(cce_pkg::REG_WIDTH_CODE, 32'hFFFF_FFF0);
    cfg_we <= 1'b0;
    send_byte(8'hC3, 4'd5, 1'b1);

    for (p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 66;
        recv_idle_pct = 7;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      if (p == 5) apply_setting($urandom, 2'($urandom_range(3, 0)), $urandom, $urandom);
      else apply_setting(POLY_SET[p], WCODE_SET[p], INIT_SET[p], XOR_SET[p]);
      if (p == 0) stall_req = 400;
      run_traffic(112);
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/cce_pkg.sv
src/cce_crc_unit.sv
src/configurable_crc_engine_core.sv
test/crc_result_checker.sv
test/tb_configurable_crc_engine_core.sv
